// ----- rtl/bpcc_pkg.sv -----
// shared constants, codes and controller/datapath signal groups of the pair checker
package bpcc_pkg;

	localparam int MAX_PAIRS         = 256;
	localparam int POSITION_BITS     = 12;
	localparam int KIND_BITS         = 2;
	localparam int STORED_COUNT_BITS = 9;
	localparam int ADDR_BITS         = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int COUNT_BITS        = $clog2(MAX_PAIRS + 1);

	localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_QUERY  = 2'd2;

	typedef logic [POSITION_BITS-1:0] pos_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic rd_en;
		logic emit;
	} bpcc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_needed;
		logic idx_last;
	} bpcc_sts_t;

endpackage

// ----- rtl/bpcc_in_if.sv -----
// input channel: one table command word per handshake
interface bpcc_in_if import bpcc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [KIND_BITS-1:0] kind;
	pos_t                 opening_position;
	pos_t                 closing_position;
	logic                 last_of_group;

	modport source (output valid, kind, opening_position, closing_position, last_of_group,
		input ready);
	modport sink (input valid, kind, opening_position, closing_position, last_of_group,
		output ready);
endinterface

// ----- rtl/bpcc_out_if.sv -----
// output channel: one result word per handshake
interface bpcc_out_if import bpcc_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic                         pair_conflicts;
	logic                         group_conflicts;
	logic                         table_full_error;
	logic [STORED_COUNT_BITS-1:0] stored_count;

	modport source (output valid, pair_conflicts, group_conflicts, table_full_error,
		stored_count, input ready);
	modport sink (input valid, pair_conflicts, group_conflicts, table_full_error,
		stored_count, output ready);
endinterface

// ----- rtl/bpcc_ctrl.sv -----
// controller state machine: accept, table scan, result hand-off
module bpcc_ctrl import bpcc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  bpcc_sts_t sts,
	output bpcc_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_FLUSH = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d   = state_q;
		cmd.load  = 1'b0;
		cmd.rd_en = 1'b0;
		cmd.emit  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = sts.scan_needed ? S_SCAN : S_DONE;
				end
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				if (sts.idx_last) begin
					state_d = S_FLUSH;
				end
			end
			// last read word is compared here
			S_FLUSH: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_no_scan_direct_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !sts.scan_needed) |=> (state_q == S_DONE))
		else $error("item without scan did not go straight to result");

	a_scan_ends_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && sts.idx_last) |=> (state_q == S_FLUSH))
		else $error("scan end not followed by flush");

	a_emit_shows_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (out_valid_q && state_q == S_IDLE))
		else $error("emitted word not presented");

endmodule

// ----- rtl/bpcc_datapath.sv -----
// datapath: pair memory, count, scan index, clash compare and result register
module bpcc_datapath import bpcc_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bpcc_cmd_t                    cmd,
	output bpcc_sts_t                    sts,
	input  logic [KIND_BITS-1:0]         kind,
	input  pos_t                         opening_position,
	input  pos_t                         closing_position,
	input  logic                         last_of_group,
	output logic                         pair_conflicts,
	output logic                         group_conflicts,
	output logic                         table_full_error,
	output logic [STORED_COUNT_BITS-1:0] stored_count
);

	function automatic logic clash(pos_t a, pos_t b, pos_t o, pos_t c);
		logic shared;
		logic into;
		logic outof;
		shared = (a == o) || (a == c) || (b == o) || (b == c);
		into   = (a <= o) && (b >= o) && (b <= c);
		outof  = (a >= o) && (a <= c) && (b >= c);
		return shared || into || outof;
	endfunction

	logic [2*POSITION_BITS-1:0] mem [0:MAX_PAIRS-1];

	logic [COUNT_BITS-1:0]      count_q;
	logic [ADDR_BITS-1:0]       idx_q;
	logic                       cmp_valid_s1;
	logic [2*POSITION_BITS-1:0] rd_data_s1;
	logic                       hit_q;
	logic                       acc_q;
	logic [KIND_BITS-1:0]       kind_q;
	pos_t                       open_q;
	pos_t                       close_q;
	logic                       last_q;
	logic                       full_q;
	logic                       has_room;
	logic                       wr_en;
	logic                       is_query;
	logic                       group_now;

	logic                         pair_q;
	logic                         group_q;
	logic                         err_q;
	logic [STORED_COUNT_BITS-1:0] cnt_out_q;

	assign has_room        = (count_q < COUNT_BITS'(MAX_PAIRS));
	assign wr_en           = cmd.load && (kind == KIND_INSERT) && has_room;
	assign sts.scan_needed = (kind == KIND_QUERY) && (count_q != '0);
	assign sts.idx_last    = ((COUNT_BITS'(idx_q) + COUNT_BITS'(1)) == count_q);

	assign is_query  = (kind_q == KIND_QUERY);
	assign group_now = acc_q || (is_query && hit_q);

	// memory: write on insert, registered read during scan
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ADDR_BITS'(count_q)] <= {opening_position, closing_position};
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[idx_q];
		end
	end

	// latched item and result word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			open_q  <= opening_position;
			close_q <= closing_position;
			last_q  <= last_of_group;
		end
		if (cmd.emit) begin
			pair_q    <= is_query && hit_q;
			group_q   <= group_now;
			err_q     <= full_q;
			cnt_out_q <= STORED_COUNT_BITS'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			idx_q        <= '0;
			cmp_valid_s1 <= 1'b0;
			hit_q        <= 1'b0;
			acc_q        <= 1'b0;
			full_q       <= 1'b0;
		end else begin
			cmp_valid_s1 <= cmd.rd_en;
			if (cmd.load) begin
				idx_q  <= '0;
				hit_q  <= 1'b0;
				full_q <= (kind == KIND_INSERT) && !has_room;
				if (kind == KIND_CLEAR) begin
					count_q <= '0;
				end else if (wr_en) begin
					count_q <= count_q + COUNT_BITS'(1);
				end
			end else begin
				if (cmd.rd_en) begin
					idx_q <= idx_q + ADDR_BITS'(1);
				end
				if (cmp_valid_s1 && clash(open_q, close_q,
						rd_data_s1[2*POSITION_BITS-1:POSITION_BITS],
						rd_data_s1[POSITION_BITS-1:0])) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.emit && is_query) begin
				acc_q <= last_q ? 1'b0 : group_now;
			end
		end
	end

	assign pair_conflicts   = pair_q;
	assign group_conflicts  = group_q;
	assign table_full_error = err_q;
	assign stored_count     = cnt_out_q;

	a_read_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (COUNT_BITS'(idx_q) < count_q))
		else $error("scan read beyond stored pairs");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_BITS'(MAX_PAIRS))
		else $error("pair count above table size");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && (kind == KIND_INSERT) && has_room |=> !full_q)
		else $error("insert with room flagged as dropped");

endmodule

// ----- rtl/base_pair_conflict_checker_core.sv -----
// top level of the base pair conflict checker
//
// in_ch carries one command word per handshake: clear the pair table, insert a
// pair, or query a pair against every stored pair. out_ch returns exactly one
// result word per command, in order.
// a query of a non-empty table scans every stored pair in the pair memory, one entry
// per cycle through its single registered read port; clear, insert and a query of
// an empty table go straight to the result without a scan.
// one command is worked on at a time; the next is accepted as soon as the
// previous result sits in the output register, even if not yet taken.
// if the receiver stalls, the result register holds its word and the next
// command waits finished until the register frees up.
// reset empties the table and clears the group accumulator; the memory itself
// is not cleared, as only entries below the count are ever read. no clearing
// pass is needed, so commands are taken straight after reset.
module base_pair_conflict_checker_core import bpcc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	bpcc_in_if.sink    in_ch,
	bpcc_out_if.source out_ch
);

	bpcc_cmd_t cmd;
	bpcc_sts_t sts;

	bpcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bpcc_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.kind             (in_ch.kind),
		.opening_position (in_ch.opening_position),
		.closing_position (in_ch.closing_position),
		.last_of_group    (in_ch.last_of_group),
		.pair_conflicts   (out_ch.pair_conflicts),
		.group_conflicts  (out_ch.group_conflicts),
		.table_full_error (out_ch.table_full_error),
		.stored_count     (out_ch.stored_count)
	);

endmodule

// ----- tb/bpcc_verdict_checker.sv -----
`timescale 1ns / 100ps
// result checker for the pair checker: predicts every result word and compares it
module bpcc_verdict_checker import bpcc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	bpcc_in_if   in_mon,
	bpcc_out_if  out_mon,
	input  logic wrap_up,
	output int   fail_count
);

	typedef struct {
		logic                         hit;
		logic                         group;
		logic                         full;
		logic [STORED_COUNT_BITS-1:0] count;
	} verdict_t;

	pos_t        open_tab [MAX_PAIRS];
	pos_t        close_tab[MAX_PAIRS];
	int unsigned held;
	logic        group_acc;
	verdict_t    awaited_verdicts[$];
	verdict_t    want;
	logic        wrapped;

	// shared endpoint, or one end inside the stored pair and the other outside
	function automatic logic pairs_clash(pos_t a, pos_t b, pos_t o, pos_t c);
		if (a == o || a == c || b == o || b == c)
			return 1'b1;
		if (a <= o && b >= o && b <= c)
			return 1'b1;
		if (a >= o && a <= c && b >= c)
			return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic clashes_with_table(pos_t a, pos_t b);
		for (int k = 0; k < held; k++)
			if (pairs_clash(a, b, open_tab[k], close_tab[k]))
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic verdict_t step_pair_table(logic [KIND_BITS-1:0] kind, pos_t a, pos_t b,
		logic last);
		verdict_t v;
		v.hit   = 1'b0;
		v.full  = 1'b0;
		v.group = group_acc;
		case (kind)
			KIND_CLEAR: held = 0;
			KIND_INSERT: begin
				if (held < MAX_PAIRS) begin
					open_tab[held]  = a;
					close_tab[held] = b;
					held++;
				end else begin
					v.full = 1'b1;
				end
			end
			KIND_QUERY: begin
				v.hit     = clashes_with_table(a, b);
				v.group   = group_acc | v.hit;
				group_acc = last ? 1'b0 : v.group;
			end
			default: ;
		endcase
		v.count = STORED_COUNT_BITS'(held);
		return v;
	endfunction

	task automatic check_field(string field, logic [STORED_COUNT_BITS-1:0] expected,
		logic [STORED_COUNT_BITS-1:0] actual);
		if (expected !== actual) begin
			$error("%s: expected %0d, got %0d", field, expected, actual);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held       = 0;
			group_acc  = 1'b0;
			wrapped    = 1'b0;
			fail_count = 0;
			awaited_verdicts.delete();
		end else begin
			if (in_mon.valid && in_mon.ready)
				awaited_verdicts.insert(awaited_verdicts.size(),
					step_pair_table(in_mon.kind, in_mon.opening_position,
					in_mon.closing_position, in_mon.last_of_group));
			if (out_mon.valid && out_mon.ready) begin
				if (awaited_verdicts.size() == 0) begin
					$error("result word with no command outstanding");
					fail_count++;
				end else begin
					want = awaited_verdicts.pop_front();
					check_field("pair_conflicts", STORED_COUNT_BITS'(want.hit),
						STORED_COUNT_BITS'(out_mon.pair_conflicts));
					check_field("group_conflicts", STORED_COUNT_BITS'(want.group),
						STORED_COUNT_BITS'(out_mon.group_conflicts));
					check_field("table_full_error", STORED_COUNT_BITS'(want.full),
						STORED_COUNT_BITS'(out_mon.table_full_error));
					check_field("stored_count", want.count, out_mon.stored_count);
				end
			end
			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (awaited_verdicts.size() != 0) begin
					$error("%0d result words never arrived", awaited_verdicts.size());
					fail_count += awaited_verdicts.size();
				end
			end
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// testbench top for the pair checker: clock, reset, command stimulus, result receiver, verdict
module tb_top;
	import bpcc_pkg::*;

	localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;
	localparam int                   POS_TOP    = (1 << POSITION_BITS) - 1;
	localparam pos_t                 POS_MAX    = pos_t'(POS_TOP);

	logic clk = 1'b0;
	logic arst_n;
	logic wrap_up;
	int   fail_count;

	bpcc_in_if  in_ch();
	bpcc_out_if out_ch();

	base_pair_conflict_checker_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	bpcc_verdict_checker verdicts (
		.clk(clk),
		.arst_n(arst_n),
		.in_mon(in_ch),
		.out_mon(out_ch),
		.wrap_up(wrap_up),
		.fail_count(fail_count)
	);

	// pairs the table should hold, used to aim queries and to decide when to clear
	pos_t placed_open[$];
	pos_t placed_close[$];
	int   words_sent, words_taken;
	int   n_clear, n_insert, n_query, n_spare, fill_runs;
	bit   in_calm, out_calm, choked;

	always #6 clk = ~clk;

	task automatic send_word(logic [KIND_BITS-1:0] kind, pos_t a, pos_t b, logic last);
		int gap;
		gap = in_calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid            <= 1'b1;
		in_ch.kind             <= kind;
		in_ch.opening_position <= a;
		in_ch.closing_position <= b;
		in_ch.last_of_group    <= last;
		do @(posedge clk); while (!in_ch.ready);
		words_sent++;
		if ($urandom_range(0, 39) == 0)
			in_calm = !in_calm;
	endtask

	task automatic issue(logic [KIND_BITS-1:0] kind, pos_t a, pos_t b, logic last);
		case (kind)
			KIND_CLEAR: begin
				placed_open.delete();
				placed_close.delete();
				n_clear++;
			end
			KIND_INSERT: begin
				if (placed_open.size() < MAX_PAIRS) begin
					placed_open.insert(placed_open.size(), a);
					placed_close.insert(placed_close.size(), b);
				end
				n_insert++;
			end
			KIND_QUERY: n_query++;
			default: n_spare++;
		endcase
		send_word(kind, a, b, last);
	endtask

	// mostly ordered pairs, short or wide, some equal ends, some random that may be reversed
	function automatic void draft_stored_pair(output pos_t a, output pos_t b);
		int r;
		int far_end;
		r = $urandom_range(0, 9);
		a = pos_t'($urandom_range(0, POS_TOP));
		if (r == 0) begin
			b = pos_t'($urandom_range(0, POS_TOP));
		end else if (r == 1) begin
			b = a;
		end else begin
			far_end = int'(a) + ((r < 6) ? $urandom_range(1, 64) : $urandom_range(1, 1024));
			b = (far_end > POS_TOP) ? pos_t'(POS_TOP) : pos_t'(far_end);
		end
	endfunction

	// query aimed at a stored pair: shared end, crossing either way, nested, enclosing or random
	function automatic void draft_probe(output pos_t a, output pos_t b);
		int   idx;
		int   o, c;
		if (placed_open.size() == 0) begin
			a = pos_t'($urandom_range(0, POS_TOP));
			b = pos_t'($urandom_range(int'(a), POS_TOP));
			return;
		end
		idx = $urandom_range(0, placed_open.size() - 1);
		o = int'(placed_open[idx]);
		c = int'(placed_close[idx]);
		case ($urandom_range(0, 6))
			0: begin
				a = ($urandom_range(0, 1) == 1) ? pos_t'(o) : pos_t'(c);
				b = pos_t'($urandom_range(0, POS_TOP));
			end
			1: begin
				a = pos_t'($urandom_range(0, o));
				b = pos_t'($urandom_range(o, c));
			end
			2: begin
				a = pos_t'($urandom_range(o, c));
				b = pos_t'($urandom_range(c, POS_TOP));
			end
			3: begin
				a = pos_t'($urandom_range(o, c));
				b = pos_t'($urandom_range(int'(a), c));
			end
			4: begin
				a = pos_t'($urandom_range(0, o));
				b = pos_t'($urandom_range(c, POS_TOP));
			end
			5: begin
				a = pos_t'($urandom_range(0, POS_TOP));
				b = pos_t'($urandom_range(int'(a), POS_TOP));
			end
			default: begin
				a = pos_t'($urandom_range(0, POS_TOP));
				b = pos_t'($urandom_range(0, POS_TOP));
			end
		endcase
	endfunction

	// mostly clear, load a set of pairs, then test another set against the table as one group
	task automatic set_test();
		int   n_pairs, n_probes, i;
		pos_t a, b;
		if ($urandom_range(0, 4) != 0 || placed_open.size() > 150)
			issue(KIND_CLEAR, pos_t'($urandom), pos_t'($urandom), 1'($urandom_range(0, 1)));
		n_pairs = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
		repeat (n_pairs) begin
			draft_stored_pair(a, b);
			issue(KIND_INSERT, a, b, 1'($urandom_range(0, 1)));
		end
		n_probes = $urandom_range(1, 6);
		for (i = 0; i < n_probes; i++) begin
			draft_probe(a, b);
			issue(KIND_QUERY, a, b, i == n_probes - 1);
		end
	endtask

	task automatic noise_words();
		repeat ($urandom_range(1, 5))
			issue(KIND_BITS'($urandom_range(0, 3)), pos_t'($urandom), pos_t'($urandom),
				1'($urandom_range(0, 1)));
	endtask

	// queries with stray last marks mixed with inserts and the odd clear
	task automatic broken_group();
		int   r;
		pos_t a, b;
		repeat ($urandom_range(2, 8)) begin
			r = $urandom_range(0, 9);
			if (r < 6) begin
				draft_probe(a, b);
				issue(KIND_QUERY, a, b, $urandom_range(0, 3) == 0);
			end else if (r < 9) begin
				draft_stored_pair(a, b);
				issue(KIND_INSERT, a, b, 1'($urandom_range(0, 1)));
			end else begin
				issue(KIND_CLEAR, pos_t'($urandom), pos_t'($urandom), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// disjoint pairs to capacity, overflow inserts, whole-table queries, spare word, clear
	task automatic fill_table_run();
		int i;
		issue(KIND_CLEAR, pos_t'($urandom), pos_t'($urandom), 1'($urandom_range(0, 1)));
		for (i = 0; i < MAX_PAIRS + 3; i++)
			issue(KIND_INSERT, pos_t'(i * 8 + 1), pos_t'(i * 8 + 5), 1'($urandom_range(0, 1)));
		issue(KIND_QUERY, 3000, 3500, 1'b0);
		issue(KIND_QUERY, 2046, POS_MAX, 1'b1);
		issue(KIND_QUERY, pos_t'((MAX_PAIRS - 1) * 8 + 3), POS_MAX, 1'b0);
		issue(KIND_QUERY, 1, 4000, 1'b1);
		issue(KIND_SPARE, pos_t'($urandom), pos_t'($urandom), 1'b1);
		issue(KIND_CLEAR, pos_t'($urandom), pos_t'($urandom), 1'b0);
		fill_runs++;
	endtask

	task automatic directed_words();
		issue(KIND_QUERY, 0, POS_MAX, 1'b1);
		issue(KIND_SPARE, POS_MAX, 0, 1'b1);
		issue(KIND_INSERT, 0, POS_MAX, 1'b1);
		issue(KIND_INSERT, 100, 200, 1'b0);
		issue(KIND_QUERY, 100, 300, 1'b0);
		// clear keeps the group result open
		issue(KIND_CLEAR, 0, 0, 1'b1);
		issue(KIND_SPARE, 0, 0, 1'b0);
		issue(KIND_QUERY, 3000, 3100, 1'b1);
		issue(KIND_INSERT, 0, POS_MAX, 1'b0);
		issue(KIND_INSERT, 1000, 2000, 1'b0);
		issue(KIND_QUERY, 500, 1500, 1'b0);
		issue(KIND_QUERY, 1500, 2500, 1'b1);
		issue(KIND_QUERY, 1200, 1800, 1'b0);
		issue(KIND_QUERY, 500, 2500, 1'b0);
		issue(KIND_QUERY, 2500, 3000, 1'b1);
		issue(KIND_INSERT, POS_MAX, 0, 1'b0);
		issue(KIND_QUERY, POS_MAX, POS_MAX, 1'b1);
		issue(KIND_QUERY, 2000, 1000, 1'b1);
		issue(KIND_QUERY, 3500, 2500, 1'b1);
		issue(KIND_INSERT, 0, 0, 1'b1);
		issue(KIND_QUERY, POS_MAX, 0, 1'b1);
		issue(KIND_CLEAR, POS_MAX, POS_MAX, 1'b0);
		issue(KIND_QUERY, 0, 0, 1'b1);
	endtask

	// result receiver, with one long hold-off so the block backs up
	initial begin
		int gap;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (words_taken == 350 && !choked) begin
				choked = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (600) @(posedge clk);
			end else begin
				gap = out_calm ? 0 : $urandom_range(0, 12);
				if (gap > 0) begin
					out_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			words_taken++;
			if ($urandom_range(0, 39) == 0)
				out_calm = !out_calm;
		end
	end

	initial begin
		#(25_000_000);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n                 <= 1'b0;
		wrap_up                <= 1'b0;
		in_ch.valid            <= 1'b0;
		in_ch.kind             <= KIND_CLEAR;
		in_ch.opening_position <= '0;
		in_ch.closing_position <= '0;
		in_ch.last_of_group    <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_words();
		while (n_clear + n_insert + n_query < 1200) begin
			if (fill_runs == 0 && n_clear + n_insert + n_query >= 500) begin
				fill_table_run();
			end else begin
				case ($urandom_range(0, 9))
					7: noise_words();
					8: broken_group();
					9: begin
						if (fill_runs < 2 && $urandom_range(0, 7) == 0)
							fill_table_run();
						else
							set_test();
					end
					default: set_test();
				endcase
			end
		end
		in_ch.valid <= 1'b0;
		while (words_taken != words_sent) @(posedge clk);
		repeat (270) @(posedge clk);
		wrap_up <= 1'b1;
		repeat (2) @(posedge clk);
		$display("covered %0d clears, %0d inserts, %0d queries, %0d unused-kind words",
			n_clear, n_insert, n_query, n_spare);
		$display("table filled to capacity %0d time(s), one long result stall", fill_runs);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- base_pair_conflict_checker_core.f -----
rtl/bpcc_pkg.sv
rtl/bpcc_in_if.sv
rtl/bpcc_out_if.sv
rtl/bpcc_ctrl.sv
rtl/bpcc_datapath.sv
rtl/base_pair_conflict_checker_core.sv
tb/bpcc_verdict_checker.sv
tb/tb_top.sv
